FILE: rtl/lljd_pkg.sv
// shared constants and types for the least loaded job dispatcher
`default_nettype none
package lljd_pkg;

  localparam int unsigned JOB_W     = 16;
  localparam int unsigned LOAD_W    = 32;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned CFG_CNT_W = 5;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned ADDR_W    = 3;

  typedef logic [JOB_W-1:0]     job_len_t;
  typedef logic [LOAD_W-1:0]    load_t;
  typedef logic [IDX_OUT_W-1:0] idx_out_t;
  typedef logic [CFG_CNT_W-1:0] cfg_cnt_t;
  typedef logic [APB_W-1:0]     apb_data_t;
  typedef logic [ADDR_W-1:0]    apb_addr_t;

  // register word index (byte address bits above the word offset)
  localparam logic [ADDR_W-3:0] REG_MACHINE_COUNT = '0;

  localparam cfg_cnt_t CNT_RESET = 5'd16;
  localparam load_t    LOAD_MAX  = '1;

endpackage
`default_nettype wire

FILE: rtl/least_loaded_job_dispatcher_top.sv
// greedy list scheduler: assigns each job to the least loaded machine
//
//  channel   signals                               direction  transaction
//  job       job_valid/job_stall + payload          in         one job length + flags
//  result    result_valid/result_stall + payload    out        chosen machine, load, makespan
//  config    psel/penable/pwrite/paddr/pwdata/...   in         machine_count at address 0
//
// each job runs a load scan over the active machines, one after another,
// through the single read port of the load memory
// job_stall is high from acceptance until the result is loaded into the output register
// a finished result waits in the output register while result_stall is high
// synchronous active-high reset clears control state and the per-machine valid bits,
// so unwritten machines read as zero load; no clearing pass is needed
`default_nettype none
module least_loaded_job_dispatcher_top #(
  parameter int unsigned MACHINES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // job channel
  input  wire logic                 job_valid,
  output      logic                 job_stall,
  input  wire lljd_pkg::job_len_t   job_length,
  input  wire logic                 first_job,
  input  wire logic                 last_job,
  // result channel
  output      logic                 result_valid,
  input  wire logic                 result_stall,
  output      lljd_pkg::idx_out_t   machine_index,
  output      lljd_pkg::load_t      new_load,
  output      lljd_pkg::load_t      makespan,
  output      logic                 is_final,
  output      logic                 overflowed,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire lljd_pkg::apb_addr_t  paddr,
  input  wire lljd_pkg::apb_data_t  pwdata,
  output      lljd_pkg::apb_data_t  prdata,
  output      logic                 pready
);
  import lljd_pkg::*;

  localparam int unsigned IW = (MACHINES > 1) ? $clog2(MACHINES) : 1;
  localparam int unsigned CW = $clog2(MACHINES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t          state;
  cfg_cnt_t        machine_count;

  // captured job
  job_len_t        job_len;
  logic            job_last;

  // load memory and per-entry valid bits (entry not yet written reads as zero)
  load_t           loads_mem [MACHINES];
  logic [MACHINES-1:0] loaded;

  // scan control and registered read port
  logic [CW-1:0]   rd_cnt;
  logic [IW-1:0]   rd_addr;
  load_t           rd_data;
  logic            rd_vld;
  logic [IW-1:0]   rd_idx;
  logic            rd_live;

  // running minimum
  logic [IW-1:0]   best_idx;
  load_t           best_load;

  // set state
  load_t           max_load;
  logic            sat_seen;

  logic [CW-1:0]   act_cnt;
  load_t           rd_value;
  logic [LOAD_W:0] sum;
  load_t           load_next;
  load_t           max_next;
  logic            job_take;
  logic            out_free;
  logic            wr_en;
  logic            cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[ADDR_W-1:2] == REG_MACHINE_COUNT);
  assign prdata = (paddr[ADDR_W-1:2] == REG_MACHINE_COUNT)
                  ? APB_W'(machine_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_count <= CNT_RESET;
    end else if (cfg_wr) begin
      machine_count <= pwdata[CFG_CNT_W-1:0];
    end
  end

  // active machine count: zero counts as one, clipped to the built count
  always_comb begin
    if (machine_count == '0) begin
      act_cnt = CW'(1);
    end else if (32'(machine_count) > 32'(MACHINES)) begin
      act_cnt = CW'(MACHINES);
    end else begin
      act_cnt = CW'(machine_count);
    end
  end

  assign job_stall = (state != S_IDLE);
  assign job_take  = job_valid && !job_stall;
  assign out_free  = !result_valid || !result_stall;
  assign rd_addr   = rd_cnt[IW-1:0];
  assign rd_value  = rd_vld ? rd_data : '0;

  // saturating add of the job onto the least loaded machine
  assign sum       = {1'b0, best_load} + (LOAD_W + 1)'(job_len);
  assign load_next = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
  assign max_next  = (load_next > max_load) ? load_next : max_load;
  assign wr_en     = (state == S_DONE) && out_free;

  // load memory: one read and one write port, read data registered
  always_ff @(posedge clk) begin
    rd_data <= loads_mem[rd_addr];
    if (wr_en) begin
      loads_mem[best_idx] <= load_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= loaded[rd_addr];
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded       <= '0;
      max_load     <= '0;
      sat_seen     <= 1'b0;
      rd_live      <= 1'b0;
      rd_cnt       <= '0;
      result_valid <= 1'b0;
    end else begin
      // a new result loaded in the same cycle keeps valid high below
      if (result_valid && !result_stall && !wr_en) begin
        result_valid <= 1'b0;
      end

      // fold the word read last cycle into the running minimum
      if (rd_live) begin
        if ((rd_idx == '0) || (rd_value < best_load)) begin
          best_idx  <= rd_idx;
          best_load <= rd_value;
        end
      end

      unique case (state)
        S_IDLE: begin
          rd_live <= 1'b0;
          if (job_take) begin
            job_len  <= job_length;
            job_last <= last_job;
            rd_cnt   <= '0;
            state    <= S_SCAN;
            // a new job set starts from empty machines
            if (first_job) begin
              loaded   <= '0;
              max_load <= '0;
              sat_seen <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          rd_live <= 1'b1;
          if (rd_cnt == act_cnt - CW'(1)) begin
            state <= S_DRAIN;
          end else begin
            rd_cnt <= rd_cnt + CW'(1);
          end
        end
        S_DRAIN: begin
          rd_live <= 1'b0;
          state   <= S_DONE;
        end
        S_DONE: begin
          rd_live <= 1'b0;
          if (out_free) begin
            loaded[best_idx] <= 1'b1;
            max_load         <= max_next;
            sat_seen         <= sat_seen | sum[LOAD_W];
            result_valid     <= 1'b1;
            machine_index    <= IDX_OUT_W'(best_idx);
            new_load         <= load_next;
            makespan         <= max_next;
            is_final         <= job_last;
            overflowed       <= sat_seen | sum[LOAD_W];
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lljd_checker.sv
// port-level checks for the least loaded job dispatcher, bound to the top level
`default_nettype none
module lljd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                job_valid,
  input wire logic                job_stall,
  input wire logic                result_valid,
  input wire logic                result_stall,
  input wire lljd_pkg::idx_out_t  machine_index,
  input wire lljd_pkg::load_t     new_load,
  input wire lljd_pkg::load_t     makespan,
  input wire logic                overflowed
);
  import lljd_pkg::*;

  // makespan covers the load just reported
  a_span_covers_load: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (makespan >= new_load))
    else $error("makespan below reported load");

  // a saturated set always has a saturated makespan
  a_overflow_span: assert property (@(posedge clk) disable iff (rst)
    (result_valid && overflowed) |-> (makespan == LOAD_MAX))
    else $error("overflow flagged without saturated makespan");

  // one job at a time: the input closes right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_stall) |=> job_stall)
    else $error("second job accepted while one is in flight");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(machine_index) && $stable(new_load) && $stable(makespan)))
    else $error("stalled result changed");

endmodule

bind least_loaded_job_dispatcher_top lljd_checker u_lljd_checker (
  .clk           (clk),
  .rst           (rst),
  .job_valid     (job_valid),
  .job_stall     (job_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .machine_index (machine_index),
  .new_load      (new_load),
  .makespan      (makespan),
  .overflowed    (overflowed)
);
`default_nettype wire

FILE: dv/tb.sv
// testbench for the least loaded job dispatcher: directed and random job sets
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lljd_pkg::*;

  localparam int unsigned MACHINE_N = 16;
  // settle time after a drain, longer than the slowest single job
  localparam int unsigned SETTLE_CYCLES = 25;
  localparam int unsigned DRAIN_LIMIT = 5000;
  // random jobs on top of the directed ones, at least 1420 jobs in all
  localparam int unsigned RANDOM_JOBS = 1400;
  localparam apb_addr_t COUNT_ADDR = {REG_MACHINE_COUNT, 2'b00};

  // what one result transaction carries
  typedef struct {
    idx_out_t machine_index;
    load_t    new_load;
    load_t    makespan;
    logic     is_final;
    logic     overflowed;
  } placement_t;

  // keeps its own copy of the machine loads and predicts every placement
  class makespan_scoreboard;
    load_t      loads[MACHINE_N];
    load_t      peak;
    logic       saturated;
    cfg_cnt_t   count;
    placement_t placements_due[$];
    int unsigned jobs_placed;
    int unsigned sets_opened;
    int unsigned results_checked;
    int unsigned overflow_results;
    int unsigned mismatches;

    function new();
      foreach (loads[m]) loads[m] = '0;
      peak = '0;
      saturated = 1'b0;
      count = CNT_RESET;
      jobs_placed = 0;
      sets_opened = 0;
      results_checked = 0;
      overflow_results = 0;
      mismatches = 0;
    endfunction

    function void set_count(cfg_cnt_t c);
      count = c;
    endfunction

    // greedy step: least loaded of the active machines, lowest index on a tie
    function void place_job(job_len_t len, logic opens_set, logic closes_set);
      int unsigned active;
      int unsigned best;
      logic [LOAD_W:0] total;
      placement_t want;
      active = (count == 0) ? 1 : ((count > MACHINE_N) ? MACHINE_N : count);
      if (opens_set) begin
        foreach (loads[m]) loads[m] = '0;
        peak = '0;
        saturated = 1'b0;
        sets_opened++;
      end
      best = 0;
      for (int m = 1; m < active; m++) begin
        if (loads[m] < loads[best]) best = m;
      end
      total = {1'b0, loads[best]} + (LOAD_W + 1)'(len);
      if (total > {1'b0, LOAD_MAX}) begin
        loads[best] = LOAD_MAX;
        saturated = 1'b1;
      end else begin
        loads[best] = total[LOAD_W-1:0];
      end
      if (loads[best] > peak) peak = loads[best];
      want.machine_index = idx_out_t'(best);
      want.new_load = loads[best];
      want.makespan = peak;
      want.is_final = closes_set;
      want.overflowed = saturated;
      placements_due = {placements_due, want};
      jobs_placed++;
    endfunction

    function void compare_field(string name, load_t want, load_t got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_placement(placement_t got);
      placement_t want;
      if (placements_due.size() == 0) begin
        $display("%0t: unexpected result, machine %0d load %0d makespan %0d",
                 $time, got.machine_index, got.new_load, got.makespan);
        mismatches++;
        return;
      end
      want = placements_due.pop_front();
      results_checked++;
      if (want.overflowed) overflow_results++;
      compare_field("machine_index", load_t'(want.machine_index), load_t'(got.machine_index));
      compare_field("new_load", want.new_load, got.new_load);
      compare_field("makespan", want.makespan, got.makespan);
      compare_field("is_final", load_t'(want.is_final), load_t'(got.is_final));
      compare_field("overflowed", load_t'(want.overflowed), load_t'(got.overflowed));
    endfunction

    // anything still pending after a drain never arrived
    function void report_missing();
      foreach (placements_due[k]) begin
        $display("%0t: missing result, expected machine %0d load %0d makespan %0d",
                 $time, placements_due[k].machine_index, placements_due[k].new_load,
                 placements_due[k].makespan);
        mismatches++;
      end
      placements_due.delete();
    endfunction
  endclass

  logic      clk;
  logic      rst = 1'b1;
  logic      job_valid = 1'b0;
  logic      job_stall;
  job_len_t  job_length = '0;
  logic      first_job = 1'b0;
  logic      last_job = 1'b0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  idx_out_t  machine_index;
  load_t     new_load;
  load_t     makespan;
  logic      is_final;
  logic      overflowed;
  logic      psel = 1'b0;
  logic      penable = 1'b0;
  logic      pwrite = 1'b0;
  apb_addr_t paddr = '0;
  apb_data_t pwdata = '0;
  apb_data_t prdata;
  logic      pready;

  // quiet turns off idling on both sides for a stretch
  bit quiet = 1'b0;
  int unsigned count_writes = 0;
  makespan_scoreboard sb;

  least_loaded_job_dispatcher_top #(.MACHINES(MACHINE_N)) dut (
    .clk, .rst,
    .job_valid, .job_stall, .job_length, .first_job, .last_job,
    .result_valid, .result_stall, .machine_index, .new_load, .makespan,
    .is_final, .overflowed,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: stall at random, about 16 percent of the time, unless quiet
  always @(posedge clk) begin
    if (quiet) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(99) < 16);
  end

  // both handshakes sampled at the edge; results checked before the job
  // of the same edge is noted so a result can never match its own job
  always @(posedge clk) begin : watch
    placement_t seen;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        seen.machine_index = machine_index;
        seen.new_load = new_load;
        seen.makespan = makespan;
        seen.is_final = is_final;
        seen.overflowed = overflowed;
        sb.check_placement(seen);
      end
      if (job_valid && !job_stall) sb.place_job(job_length, first_job, last_job);
    end
  end

  // present one job and hold it until the transaction completes; valid stays
  // high on return so a back-to-back job needs no second assignment
  task automatic send_job(job_len_t len, logic opens_set, logic closes_set);
    job_valid <= 1'b1;
    job_length <= len;
    first_job <= opens_set;
    last_job <= closes_set;
    @(posedge clk);
    while (job_stall) @(posedge clk);
  endtask

  // sender side gap between jobs
  task automatic job_pause();
    int unsigned n;
    if (!quiet && $urandom_range(99) < 16) begin
      n = $urandom_range(1, 24);
      job_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic run_job(job_len_t len, logic opens_set, logic closes_set);
    send_job(len, opens_set, closes_set);
    job_pause();
  endtask

  // wait for every pending result, then let the block go fully idle
  task automatic settle();
    int unsigned waited;
    job_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (sb.placements_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.report_missing();
  endtask

  // two-phase register write; upper data bits optionally carry noise
  task automatic write_count(cfg_cnt_t c, bit noisy);
    apb_data_t noise;
    noise = noisy ? apb_data_t'($urandom()) : '0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= COUNT_ADDR;
    pwdata <= {noise[APB_W-1:CFG_CNT_W], c};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_count(c);
    count_writes++;
  endtask

  // lengths lean toward zero, the maximum and tiny values so ties are common
  function automatic job_len_t pick_length();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return job_len_t'($urandom_range(0, 7));
      4: return job_len_t'(1 << $urandom_range(JOB_W - 1));
      default: return job_len_t'($urandom());
    endcase
  endfunction

  // mostly proper sets (opening flag first, closing flag last) with
  // occasional continuations and stray flags in the middle
  task automatic run_set();
    int unsigned len_n;
    logic opens_set;
    logic closes_set;
    len_n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
    for (int k = 0; k < len_n; k++) begin
      opens_set = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
      closes_set = (k == len_n - 1) ? 1'b1 : ($urandom_range(49) == 0);
      run_job(pick_length(), opens_set, closes_set);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned phase;
    int unsigned sets;
    cfg_cnt_t cnt;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset count of sixteen, loads start from reset, all-zero ties
    run_job(16'd0, 1'b0, 1'b0);
    run_job(16'd0, 1'b0, 1'b0);
    run_job(16'hFFFF, 1'b0, 1'b0);
    run_job(16'd1, 1'b0, 1'b0);
    run_job(16'd1, 1'b0, 1'b0);
    run_job(16'h8000, 1'b0, 1'b1);
    // opening flag clears everything, maximum length on a clean set
    run_job(16'hFFFF, 1'b1, 1'b1);
    settle();

    // single machine: every job stacks onto machine zero
    write_count(5'd1, 1'b0);
    run_job(16'hFFFF, 1'b1, 1'b0);
    run_job(16'hFFFF, 1'b0, 1'b0);
    run_job(16'd0, 1'b0, 1'b1);
    settle();

    // zero count acts as one; set continues across the change
    write_count(5'd0, 1'b0);
    run_job(16'd1, 1'b0, 1'b0);
    run_job(16'd2, 1'b0, 1'b0);
    settle();

    // counts above the built size clamp to sixteen, still mid-set
    write_count(5'd31, 1'b1);
    run_job(16'd5, 1'b0, 1'b0);
    run_job(16'd5, 1'b0, 1'b0);
    run_job(16'd5, 1'b0, 1'b0);
    settle();
    write_count(5'd17, 1'b1);
    run_job(16'd7, 1'b0, 1'b1);
    settle();

    // shrink to two: higher machines keep their loads and still set the makespan
    write_count(5'd2, 1'b0);
    run_job(16'd3, 1'b0, 1'b0);
    run_job(16'd3, 1'b0, 1'b0);
    run_job(16'd0, 1'b0, 1'b0);
    run_job(16'd9, 1'b1, 1'b1);
    settle();

    // random phases: new count each phase, a few sets each; one long quiet phase
    target = sb.jobs_placed + RANDOM_JOBS;
    phase = 0;
    while (sb.jobs_placed < target) begin
      case ($urandom_range(5))
        0: cnt = 5'd1;
        1: cnt = 5'd16;
        2: cnt = 5'd0;
        3: cnt = cfg_cnt_t'($urandom_range(17, 31));
        default: cnt = cfg_cnt_t'($urandom_range(1, 16));
      endcase
      quiet = (phase == 4);
      write_count(cnt, $urandom_range(1));
      sets = quiet ? 12 : $urandom_range(1, 4);
      repeat (sets) run_set();
      settle();
      phase++;
    end
    quiet = 1'b0;

    $display("covered %0d jobs in %0d sets over %0d machine count writes",
             sb.jobs_placed, sb.sets_opened, count_writes);
    $display("%0d results checked, %0d of them with the overflow flag set",
             sb.results_checked, sb.overflow_results);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard, several times the slowest correct run
  initial begin
    #(40_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
